// ===== src/ctst_pkg.sv =====
package ctst_pkg;

    // Field widths of the item ports
    localparam int OPCODE_W = 2;
    localparam int TAG_W    = 8;
    localparam int DATA_W   = 32;
    localparam int SLOT_W   = 6;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int PEND_W   = 8;

    localparam logic [PEND_W-1:0] PEND_MAX = '1;

    // Parameter defaults
    localparam int MAX_TASKS_DEF = 16;
    localparam int TICK_MS_DEF   = 10;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD      = 2'd0,
        OP_DELETE   = 2'd1,
        OP_TICK     = 2'd2,
        OP_DISPATCH = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD_ACK  = 3'd0,
        KIND_DEL_ACK  = 3'd1,
        KIND_TICK_ACK = 3'd2,
        KIND_RUN      = 3'd3,
        KIND_NONE     = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_NO_SLOT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_DELAY,
        S_DIV_PERIOD,
        S_PASS,
        S_FINISH
    } state_t;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [DATA_W-1:0] countdown;
        logic [DATA_W-1:0] period;
        logic [PEND_W-1:0] pending;
    } entry_t;

    // One result item, without the last flag
    typedef struct packed {
        kind_t              kind;
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [TAG_W-1:0]   tag;
        logic [COUNT_W-1:0] count;
    } res_t;

endpackage

// ===== src/ctst_ram.sv =====
module ctst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ctst_div.sv =====
module ctst_div #(
    parameter int TICK_MS = ctst_pkg::TICK_MS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ctst_pkg::DATA_W-1:0] dividend,
    output logic                        done,
    output logic [ctst_pkg::DATA_W-1:0] quotient
);

    localparam int DW = ctst_pkg::DATA_W;
    localparam int SH = $clog2(TICK_MS);
    localparam int MW = DW + 1;
    localparam int PW = DW + MW;

    // Rounded-up reciprocal of the tick length; with the extra SH bits of
    // shift the product gives the exact quotient for every 32-bit dividend
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << (DW + SH)) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
    localparam logic [MW-1:0] RECIP = MW'(RECIP_WIDE);

    logic          done_reg, done_next;
    logic [DW-1:0] q_reg, q_next;
    logic [PW-1:0] prod;

    // One multiply by the reciprocal, quotient ready the cycle after start
    always_comb
    begin
        prod      = PW'(dividend) * PW'(RECIP);
        done_next = start;
        q_next    = start ? DW'(prod >> (DW + SH)) : q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== src/cooperative_task_scheduler_table.sv =====
// Cooperative time-triggered task scheduler table.
// Input channel (in_valid/in_ready) takes one command: add, delete slot, tick
// or dispatch. Output channel (out_valid/out_ready) returns the result items;
// the final item of a command carries last = 1.
// in_ready is high only while the sequencer is idle; one command at a time.
// in_ready returns in the same cycle that out_valid of the final result rises.
// Add: two passes through the reciprocal multiplier, delay then period;
// a full table skips the divider and answers full.
// Tick and dispatch walk all N stored tasks through the table RAM, one entry
// per cycle while a dispatch walk does not pause. Delete walks the entries
// above the removed slot; a slot out of range is answered without a walk.
// Dispatch holds each run result back by one so that the last one can be
// marked; a pass with nothing pending answers "nothing ready".
// A result waits in the output register while the receiver stalls; the
// next command is still taken meanwhile. A dispatch walk pauses when a new
// run result finds both the held result and the output register occupied,
// and the final result of any command waits for a free output register.
// Reset empties the table at once (task count zero); the entries are not
// cleared, as only slots below the count are ever read.
module cooperative_task_scheduler_table #(
    parameter int MAX_TASKS = ctst_pkg::MAX_TASKS_DEF,
    parameter int TICK_MS   = ctst_pkg::TICK_MS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ctst_pkg::OPCODE_W-1:0] opcode,
    input  logic [ctst_pkg::TAG_W-1:0]    task_tag,
    input  logic [ctst_pkg::DATA_W-1:0]   delay_ms,
    input  logic [ctst_pkg::DATA_W-1:0]   period_ms,
    input  logic [ctst_pkg::SLOT_W-1:0]   slot_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ctst_pkg::KIND_W-1:0]   result_kind,
    output logic [ctst_pkg::STATUS_W-1:0] status,
    output logic [ctst_pkg::SLOT_W-1:0]   slot_out,
    output logic [ctst_pkg::TAG_W-1:0]    run_tag,
    output logic [ctst_pkg::COUNT_W-1:0]  task_count,
    output logic                          last
);

    localparam int IDX_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W   = $clog2(MAX_TASKS + 1);
    localparam int ENTRY_W = $bits(ctst_pkg::entry_t);
    localparam int SW      = ctst_pkg::SLOT_W;
    localparam int CW      = ctst_pkg::COUNT_W;
    localparam int DW      = ctst_pkg::DATA_W;

    // Control state
    ctst_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]   end_reg, end_next;
    logic               dv_reg, dv_next;
    logic               hold_valid_reg, hold_valid_next;
    logic               out_valid_reg, out_valid_next;

    // Payload
    ctst_pkg::op_t      op_reg, op_next;
    logic [ctst_pkg::TAG_W-1:0] tag_reg, tag_next;
    logic [DW-1:0]      period_reg, period_next;
    logic [SW-1:0]      slot_reg, slot_next;
    ctst_pkg::status_t  status_reg, status_next;
    logic [DW-1:0]      dq_reg, dq_next;
    ctst_pkg::res_t     hold_reg, hold_next;
    ctst_pkg::res_t     out_reg, out_next;
    logic               out_last_reg, out_last_next;

    // RAM and divider hookup
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    ctst_pkg::entry_t   ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    ctst_pkg::entry_t   rd_entry;
    logic               div_start;
    logic [DW-1:0]      div_dividend;
    logic               div_done;
    logic [DW-1:0]      div_quotient;

    // Walk helpers
    ctst_pkg::entry_t   entry_mod;
    ctst_pkg::res_t     res_new;
    logic               emit_req;
    logic               stall;
    logic               issue;
    logic               out_free;
    logic [CNT_W-1:0]   cnt_dec;

    assign rd_entry = ctst_pkg::entry_t'(ram_rdata);
    assign out_free = !out_valid_reg || out_ready;
    assign cnt_dec  = cnt_reg - CNT_W'(1);
    assign in_ready = (state_reg == ctst_pkg::S_IDLE);

    ctst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ctst_div #(
        .TICK_MS (TICK_MS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Per-entry update of the walk
    always_comb
    begin
        entry_mod = rd_entry;
        emit_req  = 1'b0;
        case (op_reg)
            ctst_pkg::OP_TICK:
            begin
                if (rd_entry.countdown != '0)
                begin
                    entry_mod.countdown = rd_entry.countdown - DW'(1);
                end
                else
                begin
                    entry_mod.countdown = rd_entry.period;
                    if (rd_entry.pending != ctst_pkg::PEND_MAX)
                    begin
                        entry_mod.pending = rd_entry.pending + ctst_pkg::PEND_W'(1);
                    end
                end
            end
            ctst_pkg::OP_DISPATCH:
            begin
                if (dv_reg && (rd_entry.pending != '0))
                begin
                    emit_req          = 1'b1;
                    entry_mod.pending = rd_entry.pending - ctst_pkg::PEND_W'(1);
                end
            end
            default:
            begin
                entry_mod = rd_entry;
            end
        endcase
        stall = emit_req && hold_valid_reg && !out_free;
        issue = !stall && (rd_ptr_reg < end_reg);
    end

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        end_next        = end_reg;
        dv_next         = dv_reg;
        hold_valid_next = hold_valid_reg;
        op_next         = op_reg;
        tag_next        = tag_reg;
        period_next     = period_reg;
        slot_next       = slot_reg;
        status_next     = status_reg;
        dq_next         = dq_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = wr_ptr_reg[IDX_W-1:0];
        ram_wdata       = entry_mod;
        ram_re          = 1'b0;
        ram_raddr       = rd_ptr_reg[IDX_W-1:0];
        div_start       = 1'b0;
        div_dividend    = delay_ms;
        res_new.kind    = ctst_pkg::KIND_RUN;
        res_new.status  = ctst_pkg::STAT_OK;
        res_new.slot    = SW'(wr_ptr_reg);
        res_new.tag     = rd_entry.tag;
        res_new.count   = CW'(cnt_reg);

        case (state_reg)
            ctst_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = ctst_pkg::op_t'(opcode);
                    tag_next    = task_tag;
                    period_next = period_ms;
                    slot_next   = slot_in;
                    status_next = ctst_pkg::STAT_OK;
                    rd_ptr_next = '0;
                    wr_ptr_next = '0;
                    end_next    = cnt_reg;
                    dv_next     = 1'b0;
                    case (ctst_pkg::op_t'(opcode))
                        ctst_pkg::OP_ADD:
                        begin
                            if (cnt_reg < CNT_W'(MAX_TASKS))
                            begin
                                div_start  = 1'b1;
                                state_next = ctst_pkg::S_DIV_DELAY;
                            end
                            else
                            begin
                                status_next = ctst_pkg::STAT_FULL;
                                state_next  = ctst_pkg::S_FINISH;
                            end
                        end
                        ctst_pkg::OP_DELETE:
                        begin
                            if (CW'(slot_in) < CW'(cnt_reg))
                            begin
                                rd_ptr_next = CNT_W'(slot_in) + CNT_W'(1);
                                wr_ptr_next = CNT_W'(slot_in);
                                state_next  = ctst_pkg::S_PASS;
                            end
                            else
                            begin
                                status_next = ctst_pkg::STAT_NO_SLOT;
                                state_next  = ctst_pkg::S_FINISH;
                            end
                        end
                        default:
                        begin
                            state_next = ctst_pkg::S_PASS;
                        end
                    endcase
                end
            end

            ctst_pkg::S_DIV_DELAY:
            begin
                if (div_done)
                begin
                    dq_next      = div_quotient;
                    div_start    = 1'b1;
                    div_dividend = period_reg;
                    state_next   = ctst_pkg::S_DIV_PERIOD;
                end
            end

            // Append the new task at the end of the table
            ctst_pkg::S_DIV_PERIOD:
            begin
                if (div_done)
                begin
                    ram_we              = 1'b1;
                    ram_waddr           = cnt_reg[IDX_W-1:0];
                    ram_wdata.tag       = tag_reg;
                    ram_wdata.countdown = dq_reg;
                    ram_wdata.period    = div_quotient;
                    ram_wdata.pending   = '0;
                    cnt_next            = cnt_reg + CNT_W'(1);
                    state_next          = ctst_pkg::S_FINISH;
                end
            end

            // Walk: read one entry ahead, rewrite compacted at wr_ptr
            ctst_pkg::S_PASS:
            begin
                ram_re = issue;
                if (issue)
                begin
                    rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                end
                if (dv_reg && !stall)
                begin
                    if (emit_req)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = hold_reg;
                            out_last_next  = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        if (rd_entry.period == '0)
                        begin
                            // one-shot task leaves the table
                            cnt_next      = cnt_dec;
                            res_new.count = CW'(cnt_dec);
                        end
                        else
                        begin
                            ram_we      = 1'b1;
                            wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                        end
                        hold_next = res_new;
                    end
                    else
                    begin
                        ram_we      = 1'b1;
                        wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                    end
                end
                dv_next = stall ? dv_reg : issue;
                if (!dv_reg && !issue)
                begin
                    state_next = ctst_pkg::S_FINISH;
                end
            end

            // Final result of the command
            ctst_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    out_next.status = status_reg;
                    out_next.slot   = '0;
                    out_next.tag    = '0;
                    out_next.count  = CW'(cnt_reg);
                    case (op_reg)
                        ctst_pkg::OP_ADD:
                        begin
                            out_next.kind = ctst_pkg::KIND_ADD_ACK;
                            if (status_reg == ctst_pkg::STAT_OK)
                            begin
                                out_next.slot = SW'(cnt_dec);
                            end
                        end
                        ctst_pkg::OP_DELETE:
                        begin
                            out_next.kind = ctst_pkg::KIND_DEL_ACK;
                            out_next.slot = slot_reg;
                            if (status_reg == ctst_pkg::STAT_OK)
                            begin
                                cnt_next       = cnt_dec;
                                out_next.count = CW'(cnt_dec);
                            end
                        end
                        ctst_pkg::OP_TICK:
                        begin
                            out_next.kind = ctst_pkg::KIND_TICK_ACK;
                        end
                        default:
                        begin
                            if (hold_valid_reg)
                            begin
                                out_next        = hold_reg;
                                hold_valid_next = 1'b0;
                            end
                            else
                            begin
                                out_next.kind = ctst_pkg::KIND_NONE;
                            end
                        end
                    endcase
                    state_next = ctst_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ctst_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ctst_pkg::S_IDLE;
            cnt_reg        <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            end_reg        <= '0;
            dv_reg         <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            end_reg        <= end_next;
            dv_reg         <= dv_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        tag_reg      <= tag_next;
        period_reg   <= period_next;
        slot_reg     <= slot_next;
        status_reg   <= status_next;
        dq_reg       <= dq_next;
        hold_reg     <= hold_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    // Output ports
    assign out_valid   = out_valid_reg;
    assign result_kind = out_reg.kind;
    assign status      = out_reg.status;
    assign slot_out    = out_reg.slot;
    assign run_tag     = out_reg.tag;
    assign task_count  = out_reg.count;
    assign last        = out_last_reg;

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_TASKS))
        else $error("task count above table size");

    a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && (state_reg == ctst_pkg::S_PASS)) |-> (wr_ptr_reg < rd_ptr_reg))
        else $error("walk write overtook read pointer");

    a_hold_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> (op_reg == ctst_pkg::OP_DISPATCH))
        else $error("held result outside dispatch");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == ctst_pkg::S_DIV_DELAY) ||
                      (state_reg == ctst_pkg::S_DIV_PERIOD)))
        else $error("divider finished outside add");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready right after a transfer");

endmodule

// ===== tb/cooperative_task_scheduler_table_test.sv =====
module cooperative_task_scheduler_table_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ctst_pkg::*;

    localparam int MAX_TASKS = MAX_TASKS_DEF;
    localparam int TICK_MS   = TICK_MS_DEF;

    // One result item as the block should return it
    typedef struct {
        kind_t              kind;
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [TAG_W-1:0]   tag;
        logic [COUNT_W-1:0] count;
        logic               last;
    } sched_result_t;

    // Shadow task table and the queue of results still owed by the block
    class task_table_predictor;
        logic [TAG_W-1:0]  tags       [MAX_TASKS];
        logic [DATA_W-1:0] countdowns [MAX_TASKS];
        logic [DATA_W-1:0] periods    [MAX_TASKS];
        logic [PEND_W-1:0] runs_owed  [MAX_TASKS];
        int                task_total;
        int                mismatches;
        sched_result_t     awaited [$];

        function new();
            task_total = 0;
            mismatches = 0;
        endfunction

        // Remove a slot, later entries move down by one
        function void drop_slot(int s);
            for (int i = s; i + 1 < task_total; i++)
            begin
                tags[i]       = tags[i + 1];
                countdowns[i] = countdowns[i + 1];
                periods[i]    = periods[i + 1];
                runs_owed[i]  = runs_owed[i + 1];
            end
            task_total--;
        endfunction

        function void queue_result(kind_t kind, status_t st, logic [SLOT_W-1:0] slot,
                                   logic [TAG_W-1:0] tag, logic last);
            sched_result_t r;
            r.kind   = kind;
            r.status = st;
            r.slot   = slot;
            r.tag    = tag;
            r.count  = COUNT_W'(task_total);
            r.last   = last;
            awaited.push_back(r);
        endfunction

        // Work out the results of one accepted command
        function void note_command(op_t op, logic [TAG_W-1:0] tag, logic [DATA_W-1:0] delay,
                                   logic [DATA_W-1:0] period, logic [SLOT_W-1:0] slot);
            int               i;
            int               emitted;
            logic [TAG_W-1:0] t;
            case (op)
                OP_ADD:
                begin
                    if (task_total < MAX_TASKS)
                    begin
                        tags[task_total]       = tag;
                        countdowns[task_total] = delay / DATA_W'(TICK_MS);
                        periods[task_total]    = period / DATA_W'(TICK_MS);
                        runs_owed[task_total]  = '0;
                        task_total++;
                        queue_result(KIND_ADD_ACK, STAT_OK, SLOT_W'(task_total - 1), '0,
                                     1'b1);
                    end
                    else
                    begin
                        queue_result(KIND_ADD_ACK, STAT_FULL, '0, '0, 1'b1);
                    end
                end
                OP_DELETE:
                begin
                    if (int'(slot) < task_total)
                    begin
                        drop_slot(int'(slot));
                        queue_result(KIND_DEL_ACK, STAT_OK, slot, '0, 1'b1);
                    end
                    else
                    begin
                        queue_result(KIND_DEL_ACK, STAT_NO_SLOT, slot, '0, 1'b1);
                    end
                end
                OP_TICK:
                begin
                    for (int k = 0; k < task_total; k++)
                    begin
                        if (countdowns[k] != 0)
                        begin
                            countdowns[k]--;
                        end
                        else
                        begin
                            countdowns[k] = periods[k];
                            if (runs_owed[k] != PEND_MAX)
                                runs_owed[k]++;
                        end
                    end
                    queue_result(KIND_TICK_ACK, STAT_OK, '0, '0, 1'b1);
                end
                default:
                begin
                    // Dispatch: one run per owed task; one-shots leave the table and
                    // the entry moved into their slot is looked at next
                    i = 0;
                    emitted = 0;
                    while (i < task_total)
                    begin
                        if (runs_owed[i] != 0)
                        begin
                            runs_owed[i]--;
                            t = tags[i];
                            if (periods[i] == 0)
                            begin
                                drop_slot(i);
                                queue_result(KIND_RUN, STAT_OK, SLOT_W'(i), t, 1'b0);
                                emitted++;
                                continue;
                            end
                            queue_result(KIND_RUN, STAT_OK, SLOT_W'(i), t, 1'b0);
                            emitted++;
                        end
                        i++;
                    end
                    if (emitted == 0)
                        queue_result(KIND_NONE, STAT_OK, '0, '0, 1'b1);
                    else
                        awaited[awaited.size() - 1].last = 1'b1;
                end
            endcase
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endfunction

        // Compare one result transfer with the oldest awaited result
        function void check_result(logic [KIND_W-1:0] kind, logic [STATUS_W-1:0] st,
                                   logic [SLOT_W-1:0] slot, logic [TAG_W-1:0] tag,
                                   logic [COUNT_W-1:0] cnt, logic last);
            sched_result_t want;
            if (awaited.size() == 0)
            begin
                note_mismatch($sformatf("unawaited result kind %0d status %0d slot %0d tag %0h",
                                        kind, st, slot, tag));
                return;
            end
            want = awaited.pop_front();
            if (kind !== want.kind || st !== want.status || slot !== want.slot ||
                tag !== want.tag || cnt !== want.count || last !== want.last)
                note_mismatch($sformatf(
                    {"exp kind %0d status %0d slot %0d tag %0h count %0d last %0d, ",
                     "got %0d %0d %0d %0h %0d %0d"},
                    want.kind, want.status, want.slot, want.tag, want.count, want.last,
                    kind, st, slot, tag, cnt, last));
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OPCODE_W-1:0] opcode;
    logic [TAG_W-1:0]    task_tag;
    logic [DATA_W-1:0]   delay_ms;
    logic [DATA_W-1:0]   period_ms;
    logic [SLOT_W-1:0]   slot_in;
    logic                out_valid;
    logic                out_ready;
    logic [KIND_W-1:0]   result_kind;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic [TAG_W-1:0]    run_tag;
    logic [COUNT_W-1:0]  task_count;
    logic                last;

    task_table_predictor sched;
    int                  accepted;
    bit                  calm;

    cooperative_task_scheduler_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .task_tag    (task_tag),
        .delay_ms    (delay_ms),
        .period_ms   (period_ms),
        .slot_in     (slot_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .status      (status),
        .slot_out    (slot_out),
        .run_tag     (run_tag),
        .task_count  (task_count),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offer one command and hold it until the transfer
    task automatic send_command(input op_t op, input logic [TAG_W-1:0] tag,
                                input logic [DATA_W-1:0] delay,
                                input logic [DATA_W-1:0] period,
                                input logic [SLOT_W-1:0] slot);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        task_tag  <= tag;
        delay_ms  <= delay;
        period_ms <= period;
        slot_in   <= slot;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sched.note_command(op, tag, delay, period, slot);
        accepted++;
    endtask

    // Result side
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sched.check_result(result_kind, status, slot_out, run_tag, task_count, last);
    end

    // Receiver stalls, with one long hold-off while commands keep coming
    initial
    begin
        int stall;
        bit held;
        held = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && accepted >= 120)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    // Stimulus and end of run
    initial
    begin
        int                r;
        int                drain;
        op_t               op;
        logic [TAG_W-1:0]  tag;
        logic [DATA_W-1:0] delay;
        logic [DATA_W-1:0] period;
        logic [SLOT_W-1:0] slot;

        sched     = new();
        accepted  = 0;
        calm      = 1'b0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        opcode    <= OP_TICK;
        task_tag  <= '0;
        delay_ms  <= '0;
        period_ms <= '0;
        slot_in   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: nothing ready, deletes out of range
        send_command(OP_DISPATCH, 8'h00, '0, '0, 6'd0);
        send_command(OP_DELETE, 8'h00, '0, '0, 6'd0);
        send_command(OP_DELETE, 8'hff, '1, '1, 6'd63);

        // One-shot due at once, extremes, sub-tick values, a short period
        send_command(OP_ADD, 8'h00, 32'd0, 32'd0, 6'd0);
        send_command(OP_ADD, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 6'd63);
        send_command(OP_ADD, 8'ha5, 32'd9, 32'd25, 6'd0);
        send_command(OP_ADD, 8'h5a, 32'd0, 32'd10, 6'd0);
        repeat (3) send_command(OP_TICK, 8'h00, '0, '0, 6'd0);

        // First dispatch removes the one-shot and goes on with the moved entry
        repeat (2) send_command(OP_DISPATCH, 8'h00, '0, '0, 6'd0);

        // Fill the table, then one add too many
        while (sched.task_total < MAX_TASKS)
            send_command(OP_ADD, 8'($urandom), 32'd20, 32'd30, 6'd0);
        send_command(OP_ADD, 8'h3c, 32'd20, 32'd30, 6'd0);

        // Last slot, first slot, one past the end
        send_command(OP_DELETE, 8'h00, '0, '0, 6'(MAX_TASKS - 1));
        send_command(OP_DELETE, 8'h00, '0, '0, 6'd0);
        send_command(OP_DELETE, 8'h00, '0, '0, 6'(MAX_TASKS - 2));

        // Random command mix
        for (int n = 0; n < 40; n++)
        begin
            calm = (n >= 5 && n < 15);
            if (n == 20)
            begin
                // A one-shot owed 256 runs: the count must stick at its maximum
                send_command(OP_DELETE, 8'($urandom), $urandom, $urandom, 6'd0);
                send_command(OP_ADD, 8'($urandom), 32'd3, 32'd9, 6'($urandom_range(0, 63)));
                repeat (256)
                    send_command(OP_TICK, 8'($urandom), $urandom, $urandom,
                                 6'($urandom_range(0, 63)));
                send_command(OP_DISPATCH, 8'($urandom), $urandom, $urandom, 6'd0);
            end
            tag    = 8'($urandom);
            delay  = $urandom;
            period = $urandom;
            slot   = 6'($urandom_range(0, 63));
            r      = $urandom_range(0, 99);
            if (r < 30)
            begin
                op = OP_ADD;
                r  = $urandom_range(0, 99);
                if (r < 70)
                    delay = $urandom_range(0, 60);
                else if (r < 92)
                    delay = $urandom_range(0, 400);
                r = $urandom_range(0, 99);
                if (r < 25)
                    period = '0;
                else if (r < 45)
                    period = $urandom_range(1, 9);
                else if (r < 95)
                    period = $urandom_range(10, 80);
            end
            else if (r < 45)
            begin
                op = OP_DELETE;
                if (sched.task_total > 0 && $urandom_range(0, 4) != 0)
                    slot = 6'($urandom_range(0, sched.task_total - 1));
            end
            else if (r < 80)
            begin
                op = OP_TICK;
            end
            else
            begin
                op = OP_DISPATCH;
            end
            send_command(op, tag, delay, period, slot);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // Drain, then let the sequencer settle
        drain = 0;
        while (sched.awaited.size() > 0 && drain < 200000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (100) @(posedge clk);
        if (sched.awaited.size() > 0)
            $display("%0d results never arrived", sched.awaited.size());
        if (sched.mismatches == 0 && sched.awaited.size() == 0)
        begin
            $display("cooperative_task_scheduler_table_test OK");
        end
        else
        begin
            $display("cooperative_task_scheduler_table_test NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #50_000_000;
        $display("timeout");
        $display("cooperative_task_scheduler_table_test NOT OK");
        $finish;
    end

endmodule
